/* rtl/lsm_pkg.sv */
// Shared types and constants of the lidar sector minimum-range monitor.
package lsm_pkg;

    // Configuration port geometry.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 19;

    // Fixed field widths.
    localparam int START_BITS = 19;
    localparam int STEP_BITS  = 18;
    localparam int MM_BITS    = 16;
    localparam int OUT_ANGLE_BITS = 32;
    localparam int MASK_BITS  = 5;

    // Sector limits in Q16 radians: pi/4 and 3pi/4.
    localparam int QPI4  = 51471;
    localparam int Q3PI4 = 154415;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_START_ANGLE   = 3'd0,
        CFG_ANGLE_STEP    = 3'd1,
        CFG_RANGE_FLOOR   = 3'd2,
        CFG_RANGE_CEILING = 3'd3,
        CFG_WARNING       = 3'd4,
        CFG_DANGER        = 3'd5
    } cfg_index_t;

    // Register reset values.
    localparam logic signed [START_BITS-1:0] START_ANGLE_RESET = -19'sd205887;
    localparam logic signed [STEP_BITS-1:0]  ANGLE_STEP_RESET  = 18'sd1144;
    localparam logic [MM_BITS-1:0] RANGE_FLOOR_RESET   = 16'd100;
    localparam logic [MM_BITS-1:0] RANGE_CEILING_RESET = 16'd12000;
    localparam logic [MM_BITS-1:0] WARNING_RESET       = 16'd500;
    localparam logic [MM_BITS-1:0] DANGER_RESET        = 16'd300;

    // Sector codes; the order matches the sector minimum table.
    typedef enum logic [1:0] {
        SEC_FRONT = 2'd0,
        SEC_LEFT  = 2'd1,
        SEC_BACK  = 2'd2,
        SEC_RIGHT = 2'd3
    } sector_t;

    // Safety level codes.
    typedef enum logic [1:0] {
        LVL_SAFE    = 2'd0,
        LVL_WARNING = 2'd1,
        LVL_DANGER  = 2'd2
    } level_t;

    // Classification of one sample as it travels through the queue.
    typedef struct packed {
        logic    hit;
        logic    last;
        sector_t sector;
    } item_ctl_t;

    // Settings used by the front part.
    typedef struct packed {
        logic signed [START_BITS-1:0] start_angle;
        logic signed [STEP_BITS-1:0]  angle_step;
        logic [MM_BITS-1:0]           range_floor_mm;
        logic [MM_BITS-1:0]           range_ceiling_mm;
    } front_cfg_t;

    // Settings used by the back part.
    typedef struct packed {
        logic [MM_BITS-1:0] warning_mm;
        logic [MM_BITS-1:0] danger_mm;
    } back_cfg_t;

endpackage

/* rtl/lsm_sample_if.sv */
// Sample channel: one lidar range reading per transaction.
interface lsm_sample_if;
    logic                        valid;
    logic                        ready;
    logic [lsm_pkg::MM_BITS-1:0] range_mm;
    logic                        range_ok;
    logic                        scan_end;

    modport source (output valid, range_mm, range_ok, scan_end, input ready);
    modport sink   (input valid, range_mm, range_ok, scan_end, output ready);
endinterface

/* rtl/lsm_result_if.sv */
// Result channel: one scan summary per transaction.
interface lsm_result_if;
    logic                                      valid;
    logic                                      ready;
    logic [lsm_pkg::MM_BITS-1:0]               nearest_mm;
    logic signed [lsm_pkg::OUT_ANGLE_BITS-1:0] nearest_angle;
    logic [lsm_pkg::MM_BITS-1:0]               front_mm;
    logic [lsm_pkg::MM_BITS-1:0]               left_mm;
    logic [lsm_pkg::MM_BITS-1:0]               back_mm;
    logic [lsm_pkg::MM_BITS-1:0]               right_mm;
    logic [lsm_pkg::MASK_BITS-1:0]             empty_mask;
    logic [1:0]                                safety_level;

    modport source (output valid, nearest_mm, nearest_angle, front_mm, left_mm, back_mm,
                    right_mm, empty_mask, safety_level, input ready);
    modport sink   (input valid, nearest_mm, nearest_angle, front_mm, left_mm, back_mm,
                    right_mm, empty_mask, safety_level, output ready);
endinterface

/* rtl/lsm_cfg_if.sv */
// Configuration write channel: register index and write data.
interface lsm_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [lsm_pkg::CFG_INDEX_BITS-1:0] reg_index;
    logic [lsm_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, reg_index, data, input ready);
    modport sink   (input valid, reg_index, data, output ready);
endinterface

/* rtl/lsm_front.sv */
// Front part: angle accumulator, range window check and sector classification.
module lsm_front #(
    parameter int RANGE_BITS = 16,
    parameter int ANGLE_BITS = 32,
    localparam int ITEM_BITS = $bits(lsm_pkg::item_ctl_t) + RANGE_BITS + ANGLE_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    lsm_sample_if.sink                         sample,
    input  lsm_pkg::front_cfg_t                cfg,
    input  logic                               reload,
    input  logic [lsm_pkg::START_BITS-1:0]     reload_angle,
    output logic                               q_valid,
    input  logic                               q_ready,
    output logic [ITEM_BITS-1:0]               q_data
);

    localparam int RW = (RANGE_BITS > lsm_pkg::MM_BITS) ? RANGE_BITS : lsm_pkg::MM_BITS;
    localparam logic [RW-1:0] RMAX_W = RW'((1 << RANGE_BITS) - 1);
    localparam logic signed [ANGLE_BITS-1:0] PI4  = ANGLE_BITS'(lsm_pkg::QPI4);
    localparam logic signed [ANGLE_BITS-1:0] PI34 = ANGLE_BITS'(lsm_pkg::Q3PI4);
    localparam logic signed [ANGLE_BITS-1:0] ANGLE_RESET =
        ANGLE_BITS'(lsm_pkg::START_ANGLE_RESET);

    logic signed [ANGLE_BITS-1:0] angle_acc_reg, angle_acc_next;
    logic signed [ANGLE_BITS-1:0] start_ext, step_ext;
    logic                         accept;
    logic [RW-1:0]                range_wide, range_sat;
    logic [RANGE_BITS-1:0]        range_val;
    lsm_pkg::item_ctl_t           ctl;

    assign accept    = sample.valid && q_ready;
    assign start_ext = ANGLE_BITS'($signed(cfg.start_angle));
    assign step_ext  = ANGLE_BITS'($signed(cfg.angle_step));

    // The accumulator reloads on a start angle write and at the end of every scan.
    always_comb
    begin
        angle_acc_next = angle_acc_reg;
        if (reload)
        begin
            angle_acc_next = ANGLE_BITS'($signed(reload_angle));
        end
        else if (accept)
        begin
            if (sample.scan_end)
            begin
                angle_acc_next = start_ext;
            end
            else
            begin
                angle_acc_next = angle_acc_reg + step_ext;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_acc_reg <= ANGLE_RESET;
        end
        else
        begin
            angle_acc_reg <= angle_acc_next;
        end
    end

    // Saturate the range to the stored width.
    assign range_wide = RW'(sample.range_mm);
    assign range_sat  = (range_wide > RMAX_W) ? RMAX_W : range_wide;
    assign range_val  = RANGE_BITS'(range_sat);

    // Window check and sector of the current angle.
    always_comb
    begin
        ctl.hit  = sample.range_ok && (sample.range_mm >= cfg.range_floor_mm)
                   && (sample.range_mm <= cfg.range_ceiling_mm);
        ctl.last = sample.scan_end;
        if ((angle_acc_reg >= -PI4) && (angle_acc_reg <= PI4))
        begin
            ctl.sector = lsm_pkg::SEC_FRONT;
        end
        else if ((angle_acc_reg > PI4) && (angle_acc_reg <= PI34))
        begin
            ctl.sector = lsm_pkg::SEC_LEFT;
        end
        else if ((angle_acc_reg < -PI4) && (angle_acc_reg >= -PI34))
        begin
            ctl.sector = lsm_pkg::SEC_RIGHT;
        end
        else
        begin
            ctl.sector = lsm_pkg::SEC_BACK;
        end
    end

    assign sample.ready = q_ready;
    assign q_valid      = sample.valid;
    assign q_data       = {ctl, range_val, angle_acc_reg};

endmodule

/* rtl/lsm_queue.sv */
// Two-entry queue that decouples the front part from the back part.
module lsm_queue #(
    parameter int WIDTH = 52
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // Storage slots.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

/* rtl/lsm_back.sv */
// Back part: running minimums, scan summary and the result register.
module lsm_back #(
    parameter int RANGE_BITS = 16,
    parameter int ANGLE_BITS = 32,
    localparam int ITEM_BITS = $bits(lsm_pkg::item_ctl_t) + RANGE_BITS + ANGLE_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  logic [ITEM_BITS-1:0] q_data,
    input  lsm_pkg::back_cfg_t   cfg,
    lsm_result_if.source         result
);

    localparam int CTL_BITS = $bits(lsm_pkg::item_ctl_t);
    localparam int RW = (RANGE_BITS > lsm_pkg::MM_BITS) ? RANGE_BITS : lsm_pkg::MM_BITS;
    localparam int MB = lsm_pkg::MM_BITS;

    lsm_pkg::item_ctl_t           ctl;
    logic [RANGE_BITS-1:0]        val;
    logic signed [ANGLE_BITS-1:0] ang;
    logic                         pop;

    logic [RANGE_BITS-1:0]        nearest_reg, nearest_next;
    logic signed [ANGLE_BITS-1:0] nearest_angle_reg, nearest_angle_next;
    logic [RANGE_BITS-1:0]        sector_min_reg [4];
    logic [RANGE_BITS-1:0]        sector_min_next [4];
    logic [lsm_pkg::MASK_BITS-1:0] seen_reg, seen_next;
    lsm_pkg::level_t              level;

    logic                                      res_valid_reg;
    logic [MB-1:0]                             res_nearest_reg;
    logic signed [lsm_pkg::OUT_ANGLE_BITS-1:0] res_angle_reg;
    logic [MB-1:0]                             res_sector_reg [4];
    logic [lsm_pkg::MASK_BITS-1:0]             res_mask_reg;
    lsm_pkg::level_t                           res_level_reg;

    assign ctl = lsm_pkg::item_ctl_t'(q_data[ITEM_BITS-1 -: CTL_BITS]);
    assign val = q_data[ANGLE_BITS +: RANGE_BITS];
    assign ang = $signed(q_data[ANGLE_BITS-1:0]);

    // Take the next item whenever the result register can take a summary.
    assign q_ready = !res_valid_reg || result.ready;
    assign pop     = q_valid && q_ready;

    // Minimum updates; ties keep the earlier sample.
    always_comb
    begin
        nearest_next       = nearest_reg;
        nearest_angle_next = nearest_angle_reg;
        sector_min_next    = sector_min_reg;
        seen_next          = seen_reg;
        if (ctl.hit)
        begin
            if (!seen_reg[0] || (val < nearest_reg))
            begin
                nearest_next       = val;
                nearest_angle_next = ang;
            end
            if (!seen_reg[{1'b0, ctl.sector} + 3'd1] || (val < sector_min_reg[ctl.sector]))
            begin
                sector_min_next[ctl.sector] = val;
            end
            seen_next = seen_reg | 5'b00001 | (5'b00010 << ctl.sector);
        end
    end

    // Safety level from the finished minimum; danger is tested first.
    always_comb
    begin
        level = lsm_pkg::LVL_SAFE;
        if (seen_next[0])
        begin
            if (RW'(nearest_next) < RW'(cfg.danger_mm))
            begin
                level = lsm_pkg::LVL_DANGER;
            end
            else if (RW'(nearest_next) < RW'(cfg.warning_mm))
            begin
                level = lsm_pkg::LVL_WARNING;
            end
        end
    end

    // Scan state; a scan end clears everything but the nearest angle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nearest_reg       <= '1;
            nearest_angle_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                sector_min_reg[i] <= '1;
            end
            seen_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                nearest_angle_reg <= nearest_angle_next;
                if (ctl.last)
                begin
                    nearest_reg <= '1;
                    for (int i = 0; i < 4; i++)
                    begin
                        sector_min_reg[i] <= '1;
                    end
                    seen_reg <= '0;
                end
                else
                begin
                    nearest_reg    <= nearest_next;
                    sector_min_reg <= sector_min_next;
                    seen_reg       <= seen_next;
                end
            end
            if (pop && ctl.last)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (pop && ctl.last)
        begin
            res_nearest_reg <= MB'(nearest_next);
            res_angle_reg   <= lsm_pkg::OUT_ANGLE_BITS'(nearest_angle_next);
            for (int i = 0; i < 4; i++)
            begin
                res_sector_reg[i] <= MB'(sector_min_next[i]);
            end
            res_mask_reg  <= ~seen_next;
            res_level_reg <= level;
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.nearest_mm    = res_nearest_reg;
    assign result.nearest_angle = res_angle_reg;
    assign result.front_mm      = res_sector_reg[lsm_pkg::SEC_FRONT];
    assign result.left_mm       = res_sector_reg[lsm_pkg::SEC_LEFT];
    assign result.back_mm       = res_sector_reg[lsm_pkg::SEC_BACK];
    assign result.right_mm      = res_sector_reg[lsm_pkg::SEC_RIGHT];
    assign result.empty_mask    = res_mask_reg;
    assign result.safety_level  = res_level_reg;

endmodule

/* rtl/lidar_sector_min_range_monitor.sv */
// Top level of the lidar sector minimum-range monitor.
//
// Usage: range samples enter on the sample channel, one per transaction, with
// range_ok marking a numeric reading and scan_end marking the last sample of
// a scan. Each sample gets the current angle of an accumulator that starts at
// start_angle and advances by angle_step per sample. The sample that carries
// scan_end produces one transaction on the result channel with the overall
// and per-sector minimums, the empty mask and the safety level; all other
// samples produce none. Registers are written on the cfg channel, which is
// always ready; writing start_angle also reloads the angle accumulator.
// Throughput is one sample per cycle while the result channel does not stall:
// the front part classifies a sample in the cycle it is taken, and the back
// part folds one sample a cycle into the minimums. The scan_end sample reaches
// the result through the queue slot and then the result register. A two-entry
// queue sits between the parts. While the result receiver stalls with a summary
// pending, the back part holds and the queue fills, after which the sample
// channel drops ready. Reset loads the register defaults, clears the minimums
// to all ones and the nearest angle to zero, and empties the queue.
module lidar_sector_min_range_monitor #(
    parameter int RANGE_BITS = 16,
    parameter int ANGLE_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    lsm_sample_if.sink    sample,
    lsm_result_if.source  result,
    lsm_cfg_if.sink       cfg
);

    localparam int ITEM_BITS = $bits(lsm_pkg::item_ctl_t) + RANGE_BITS + ANGLE_BITS;

    lsm_pkg::front_cfg_t  front_cfg_reg;
    lsm_pkg::back_cfg_t   back_cfg_reg;
    logic                 reload;
    logic                 fq_valid, fq_ready, bq_valid, bq_ready;
    logic [ITEM_BITS-1:0] fq_data, bq_data;

    assign cfg.ready = 1'b1;
    assign reload    = cfg.valid && (cfg.reg_index == lsm_pkg::CFG_START_ANGLE);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_cfg_reg.start_angle      <= lsm_pkg::START_ANGLE_RESET;
            front_cfg_reg.angle_step       <= lsm_pkg::ANGLE_STEP_RESET;
            front_cfg_reg.range_floor_mm   <= lsm_pkg::RANGE_FLOOR_RESET;
            front_cfg_reg.range_ceiling_mm <= lsm_pkg::RANGE_CEILING_RESET;
            back_cfg_reg.warning_mm        <= lsm_pkg::WARNING_RESET;
            back_cfg_reg.danger_mm         <= lsm_pkg::DANGER_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.reg_index)
                lsm_pkg::CFG_START_ANGLE:
                begin
                    front_cfg_reg.start_angle <= cfg.data[lsm_pkg::START_BITS-1:0];
                end
                lsm_pkg::CFG_ANGLE_STEP:
                begin
                    front_cfg_reg.angle_step <= cfg.data[lsm_pkg::STEP_BITS-1:0];
                end
                lsm_pkg::CFG_RANGE_FLOOR:
                begin
                    front_cfg_reg.range_floor_mm <= cfg.data[lsm_pkg::MM_BITS-1:0];
                end
                lsm_pkg::CFG_RANGE_CEILING:
                begin
                    front_cfg_reg.range_ceiling_mm <= cfg.data[lsm_pkg::MM_BITS-1:0];
                end
                lsm_pkg::CFG_WARNING:
                begin
                    back_cfg_reg.warning_mm <= cfg.data[lsm_pkg::MM_BITS-1:0];
                end
                lsm_pkg::CFG_DANGER:
                begin
                    back_cfg_reg.danger_mm <= cfg.data[lsm_pkg::MM_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Front part: angle and classification.
    lsm_front #(
        .RANGE_BITS (RANGE_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .cfg          (front_cfg_reg),
        .reload       (reload),
        .reload_angle (cfg.data[lsm_pkg::START_BITS-1:0]),
        .q_valid      (fq_valid),
        .q_ready      (fq_ready),
        .q_data       (fq_data)
    );

    // Queue between the two parts.
    lsm_queue #(
        .WIDTH (ITEM_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (bq_valid),
        .out_ready (bq_ready),
        .out_data  (bq_data)
    );

    // Back part: minimums and scan summary.
    lsm_back #(
        .RANGE_BITS (RANGE_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (bq_valid),
        .q_ready (bq_ready),
        .q_data  (bq_data),
        .cfg     (back_cfg_reg),
        .result  (result)
    );

endmodule
